@@ sv/kcd_pkg.sv @@
// shared types and constants for the key click / double click / long press detector
// depends on nothing; used by kcd_core and key_click_double_long_detector
package kcd_pkg;

  localparam int unsigned REG_W = 16;
  localparam int unsigned CFG_INDEX_W = 8;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SCAN_PERIOD = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_WINDOW = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_TIME = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LEVEL = 8'd3;

  // reset values of the configuration registers
  localparam logic [REG_W-1:0] RST_SCAN_PERIOD = 16'd10;
  localparam logic [REG_W-1:0] RST_DOUBLE_WINDOW = 16'd200;
  localparam logic [REG_W-1:0] RST_LONG_TIME = 16'd2000;
  localparam logic RST_ACTIVE_LEVEL = 1'b0;

  typedef enum logic [1:0] {
    KEY_UP           = 2'd0,
    KEY_PRESS_BOUNCE = 2'd1,
    KEY_HELD         = 2'd2,
    KEY_UP_BOUNCE    = 2'd3
  } key_state_t;

  typedef struct packed {
    logic [REG_W-1:0] scan_period;
    logic [REG_W-1:0] double_window;
    logic [REG_W-1:0] long_time;
    logic             active_level;
  } cfg_t;

  typedef struct packed {
    logic click;
    logic dbl_click;
    logic long_press;
  } evt_t;

endpackage

@@ sv/kcd_core.sv @@
// debounce state machine and tick counters for one key
// depends on kcd_pkg (key_state_t, cfg_t, evt_t)
module kcd_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic          key_level,
  input  kcd_pkg::cfg_t cfg,
  output kcd_pkg::evt_t evt
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > kcd_pkg::REG_W) ? COUNT_WIDTH : kcd_pkg::REG_W;

  kcd_pkg::key_state_t key_state, key_state_next;
  logic [COUNT_WIDTH-1:0] scan_count, since_press_count, hold_count;
  logic [COUNT_WIDTH-1:0] scan_inc, since_inc, hold_inc;
  logic press_pending, double_seen;

  logic pressed, scan_hit, since_hit, hold_hit, confirm;

  // saturating increments
  assign scan_inc  = (&scan_count) ? scan_count : scan_count + 1'b1;
  assign since_inc = (&since_press_count) ? since_press_count : since_press_count + 1'b1;
  assign hold_inc  = (&hold_count) ? hold_count : hold_count + 1'b1;

  assign pressed   = (key_level == cfg.active_level);
  assign scan_hit  = CMP_W'(scan_inc) >= CMP_W'(cfg.scan_period);
  assign since_hit = CMP_W'(since_inc) >= CMP_W'(cfg.double_window);
  assign hold_hit  = CMP_W'(hold_inc) >= CMP_W'(cfg.long_time);

  always_comb begin
    key_state_next = key_state;
    if (scan_hit) begin
      case (key_state)
        kcd_pkg::KEY_UP: begin
          if (pressed) key_state_next = kcd_pkg::KEY_PRESS_BOUNCE;
        end
        kcd_pkg::KEY_PRESS_BOUNCE: begin
          if (pressed) key_state_next = kcd_pkg::KEY_HELD;
        end
        kcd_pkg::KEY_HELD: begin
          if (!pressed || (!double_seen && hold_hit)) key_state_next = kcd_pkg::KEY_UP_BOUNCE;
        end
        kcd_pkg::KEY_UP_BOUNCE: begin
          if (!pressed) key_state_next = kcd_pkg::KEY_UP;
        end
        default: key_state_next = kcd_pkg::KEY_UP;
      endcase
    end
  end

  always_comb begin
    evt     = '0;
    confirm = 1'b0;
    if (scan_hit) begin
      case (key_state)
        kcd_pkg::KEY_UP: begin
          evt.click = !pressed && press_pending && since_hit;
        end
        kcd_pkg::KEY_PRESS_BOUNCE: begin
          confirm       = pressed;
          evt.dbl_click = pressed && press_pending;
        end
        kcd_pkg::KEY_HELD: begin
          evt.long_press = pressed && !double_seen && hold_hit;
        end
        default: begin
          evt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_state         <= kcd_pkg::KEY_UP;
      scan_count        <= '0;
      since_press_count <= '0;
      hold_count        <= '0;
      press_pending     <= 1'b0;
      double_seen       <= 1'b0;
    end else if (step) begin
      key_state         <= key_state_next;
      scan_count        <= scan_hit ? '0 : scan_inc;
      since_press_count <= confirm ? '0 : since_inc;
      hold_count        <= confirm ? '0 : hold_inc;
      if (confirm) begin
        // second press clears pending and marks the double; first press arms it
        press_pending <= !press_pending;
        double_seen   <= press_pending;
      end else if (evt.click || evt.long_press) begin
        press_pending <= 1'b0;
      end
    end
  end

endmodule

@@ sv/key_click_double_long_detector.sv @@
// top level of the key click / double click / long press detector
// depends on kcd_pkg and kcd_core
//
// usage:
//   s_* stream: one word per tick, s_tdata[0] is the raw key pin level
//   m_* stream: one word per input word, m_tdata bits from low up are
//     click, dbl_click, long_press, event_res (any of the three)
//   cfg_* channel: register writes, cfg_index selects scan period (0),
//     double click window (1), long press time (2), active level (3);
//     other indexes are ignored; cfg_ready is always high
// output: the result word is registered and appears in the cycle after its tick word is taken
// throughput: one word per cycle; the input is taken whenever the output
//   register is empty or its word is being taken in the same cycle
// stall: when the receiver holds m_tready low the result word stays put
//   and s_tready drops, so no tick is lost or counted twice
// reset: rst (synchronous) puts the key machine in the up state, clears all
//   counters and flags, empties the output register and restores the
//   register defaults 10, 200, 2000 and active low
module key_click_double_long_detector #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // key_level, zero fill
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [7:0]                       m_tdata,   // click, dbl_click, long_press,
                                                      // event_res, zero fill
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kcd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [kcd_pkg::REG_W-1:0]        cfg_data
);

  kcd_pkg::cfg_t cfg;
  kcd_pkg::evt_t evt;
  logic          step;

  // input taken when the output register is free or draining
  assign s_tready  = !m_tvalid || m_tready;
  assign step      = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_period   <= kcd_pkg::RST_SCAN_PERIOD;
      cfg.double_window <= kcd_pkg::RST_DOUBLE_WINDOW;
      cfg.long_time     <= kcd_pkg::RST_LONG_TIME;
      cfg.active_level  <= kcd_pkg::RST_ACTIVE_LEVEL;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kcd_pkg::REG_SCAN_PERIOD:   cfg.scan_period   <= cfg_data;
        kcd_pkg::REG_DOUBLE_WINDOW: cfg.double_window <= cfg_data;
        kcd_pkg::REG_LONG_TIME:     cfg.long_time     <= cfg_data;
        kcd_pkg::REG_ACTIVE_LEVEL:  cfg.active_level  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // counters and key machine, advanced once per accepted tick
  kcd_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .key_level (s_tdata[0]),
    .cfg       (cfg),
    .evt       (evt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {4'b0000, (evt.click || evt.dbl_click || evt.long_press),
                  evt.long_press, evt.dbl_click, evt.click};
    end
  end

endmodule

@@ test/tb_key_click_double_long_detector.sv @@
// self-checking testbench for the key click / double click / long press detector
// depends on kcd_pkg and key_click_double_long_detector; a local event predictor
// models every tick and each result word is checked against it in order
module tb_key_click_double_long_detector;

  localparam int unsigned REG_W = kcd_pkg::REG_W;
  localparam int unsigned CFG_INDEX_W = kcd_pkg::CFG_INDEX_W;

  localparam int unsigned CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // an index that maps to no register, written once to show it is ignored
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 8'd9;

  // idle modes of the two stream sides
  localparam int MODE_FLOW = 0;
  localparam int MODE_SEND_IDLE = 1;
  localparam int MODE_RECV_STALL = 2;
  localparam int MODE_BOTH = 3;
  localparam int SEND_IDLE_PCT [4] = '{0, 63, 0, 29};
  localparam int RECV_STALL_PCT [4] = '{0, 0, 63, 29};

  localparam int HOLDOFF_CYCLES = 60;

  // short hand-made sequence, first tick in the top bit, pressed is level 1:
  // bounce in down-bounce, press held through up-bounce, double click whose
  // long hold is suppressed, long press, then a plain click after the window
  localparam int DIRECTED_LEN = 25;
  localparam logic [DIRECTED_LEN-1:0] DIRECTED_LEVELS = 25'b1010101111100111110110000;

  // result word fields, lowest bit last
  typedef struct packed {
    logic any_event;
    logic long_press;
    logic dbl_click;
    logic click;
  } key_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;      // key_level, zero fill
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;           // click, dbl_click, long_press, event_res, zero fill
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  key_click_double_long_detector dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of the registers
  logic [REG_W-1:0] scan_period_r = kcd_pkg::RST_SCAN_PERIOD;
  logic [REG_W-1:0] window_r = kcd_pkg::RST_DOUBLE_WINDOW;
  logic [REG_W-1:0] long_time_r = kcd_pkg::RST_LONG_TIME;
  logic active_level_r = kcd_pkg::RST_ACTIVE_LEVEL;

  // predictor copy of the detector state
  kcd_pkg::key_state_t key_st = kcd_pkg::KEY_UP;
  logic [CNT_W-1:0] scan_cnt = '0;
  logic [CNT_W-1:0] since_press_cnt = '0;
  logic [CNT_W-1:0] hold_cnt = '0;
  logic press_pending = 1'b0;
  logic double_seen = 1'b0;

  logic key_levels [$];          // ticks waiting to be offered
  key_report_t expected_reports [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit holdoff_req = 1'b0;
  int holdoff_left = 0;

  int ticks_taken = 0;
  int reports_seen = 0;
  int clicks_seen = 0;
  int doubles_seen = 0;
  int longs_seen = 0;
  int settings_run = 0;
  int mismatches = 0;

  key_report_t got_report;
  key_report_t want_report;

  initial begin
    forever #2 clk = ~clk;
  end

  // one tick of the detector: counters, then the scan-time machine step
  task automatic detect_key_events(input logic level);
    logic pressed;
    key_report_t rep;
    pressed = (level == active_level_r);
    rep = '0;
    if (scan_cnt != CNT_MAX) scan_cnt = scan_cnt + 1'b1;
    if (since_press_cnt != CNT_MAX) since_press_cnt = since_press_cnt + 1'b1;
    if (hold_cnt != CNT_MAX) hold_cnt = hold_cnt + 1'b1;
    // a zero scan period simply evaluates every tick
    if (scan_cnt >= scan_period_r) begin
      scan_cnt = '0;
      case (key_st)
        kcd_pkg::KEY_UP: begin
          if (pressed) begin
            key_st = kcd_pkg::KEY_PRESS_BOUNCE;
          end else if (press_pending && since_press_cnt >= window_r) begin
            rep.click = 1'b1;
            press_pending = 1'b0;
          end
        end
        kcd_pkg::KEY_PRESS_BOUNCE: begin
          // a released reading here just waits for the next pressed scan
          if (pressed) begin
            key_st = kcd_pkg::KEY_HELD;
            if (press_pending) begin
              rep.dbl_click = 1'b1;
              press_pending = 1'b0;
              double_seen = 1'b1;
            end else begin
              press_pending = 1'b1;
              double_seen = 1'b0;
            end
            since_press_cnt = '0;
            hold_cnt = '0;
          end
        end
        kcd_pkg::KEY_HELD: begin
          if (pressed) begin
            // second press of a double click never turns into a long press
            if (!double_seen && hold_cnt >= long_time_r) begin
              key_st = kcd_pkg::KEY_UP_BOUNCE;
              rep.long_press = 1'b1;
              press_pending = 1'b0;
            end
          end else begin
            key_st = kcd_pkg::KEY_UP_BOUNCE;
          end
        end
        default: begin
          if (!pressed) key_st = kcd_pkg::KEY_UP;
        end
      endcase
    end
    rep.any_event = rep.click | rep.dbl_click | rep.long_press;
    expected_reports.push_back(rep);
  endtask

  // tick driver: predicts on every taken word, then offers the next level
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        detect_key_events(s_tdata[0]);
        ticks_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (key_levels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tdata <= {7'd0, key_levels.pop_front()};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with a counted hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (holdoff_left > 0) begin
      m_tready <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_req) begin
      holdoff_req = 1'b0;
      holdoff_left <= HOLDOFF_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result monitor: every taken word against the oldest expected report
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_report = key_report_t'(m_tdata[3:0]);
      if (expected_reports.size() == 0) begin
        $display("%0t: result word %h with no tick pending", $time, m_tdata);
        mismatches++;
      end else begin
        want_report = expected_reports.pop_front();
        if (m_tdata[7:4] !== 4'd0 || got_report !== want_report) begin
          $display("%0t: word %0d expected click=%b double=%b long=%b event=%b fill=0",
                   $time, reports_seen, want_report.click, want_report.dbl_click,
                   want_report.long_press, want_report.any_event);
          $display("%0t: word %0d actual   click=%b double=%b long=%b event=%b fill=%h",
                   $time, reports_seen, got_report.click, got_report.dbl_click,
                   got_report.long_press, got_report.any_event, m_tdata[7:4]);
          mismatches++;
        end
        if (want_report.click) clicks_seen++;
        if (want_report.dbl_click) doubles_seen++;
        if (want_report.long_press) longs_seen++;
      end
      reports_seen++;
    end
  end

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [REG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      kcd_pkg::REG_SCAN_PERIOD: scan_period_r = value;
      kcd_pkg::REG_DOUBLE_WINDOW: window_r = value;
      kcd_pkg::REG_LONG_TIME: long_time_r = value;
      kcd_pkg::REG_ACTIVE_LEVEL: active_level_r = value[0];
      default: ;
    endcase
  endtask

  // a run of ticks at one key position, with optional contact bounce
  task automatic push_key_run(input bit pressed, input int ticks, input int bounce_pct);
    logic level;
    for (int i = 0; i < ticks; i++) begin
      level = pressed ? active_level_r : ~active_level_r;
      if ($urandom_range(99) < bounce_pct) level = ~level;
      key_levels.push_back(level);
    end
  endtask

  // mostly well-formed presses and gaps sized to the current timing, some noise
  task automatic queue_key_activity(input int n);
    int total;
    int sp;
    int hold;
    int gap;
    int bounce;
    int kind;
    total = 0;
    sp = (scan_period_r == 0) ? 1 : ((scan_period_r > 50) ? 7 : int'(scan_period_r));
    while (total < n) begin
      kind = $urandom_range(99);
      if (kind < 12) begin
        hold = $urandom_range(1, 8);
        for (int i = 0; i < hold; i++) key_levels.push_back(1'($urandom_range(1)));
        total += hold;
      end else begin
        bounce = ($urandom_range(3) == 0) ? 20 : 0;
        if (kind < 45) hold = sp * $urandom_range(2, 4);
        else if (kind < 70) hold = int'(long_time_r) + sp * $urandom_range(1, 4);
        else hold = sp * $urandom_range(2, 10);
        if (hold > 200) hold = 200;
        if ($urandom_range(99) < 45) gap = sp * $urandom_range(1, 3);
        else gap = int'(window_r) + sp * $urandom_range(2, 5);
        if (gap > 150) gap = 150;
        push_key_run(1'b1, hold, bounce);
        push_key_run(1'b0, gap, bounce);
        total += hold + gap;
      end
    end
  endtask

  // block idle: nothing queued, nothing offered, nothing outstanding
  task automatic wait_drained();
    while (key_levels.size() != 0 || s_tvalid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_timing(input logic [REG_W-1:0] sp, input logic [REG_W-1:0] win,
                                input logic [REG_W-1:0] lng, input logic act);
    logic [REG_W-1:0] level_word;
    level_word = REG_W'($urandom);
    level_word[0] = act;
    write_register(kcd_pkg::REG_SCAN_PERIOD, sp);
    write_register(kcd_pkg::REG_DOUBLE_WINDOW, win);
    write_register(kcd_pkg::REG_LONG_TIME, lng);
    write_register(kcd_pkg::REG_ACTIVE_LEVEL, level_word);
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  task automatic run_phase(input int mode, input int n, input bit pressure);
    int mark;
    send_idle_pct = SEND_IDLE_PCT[mode];
    recv_stall_pct = RECV_STALL_PCT[mode];
    mark = ticks_taken + 40;
    queue_key_activity(n);
    if (pressure) begin
      // receiver stops long enough for the output register to back up
      while (ticks_taken < mark) @(posedge clk);
      holdoff_req = 1'b1;
    end
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults straight out of reset
    settings_run++;
    run_phase(MODE_FLOW, 100, 1'b0);

    // directed sequence with a zero scan period, active high
    program_timing(16'd0, 16'd4, 16'd3, 1'b1);
    for (int i = DIRECTED_LEN - 1; i >= 0; i--) key_levels.push_back(DIRECTED_LEVELS[i]);
    wait_drained();

    program_timing(16'd2, 16'd12, 16'd20, 1'b0);
    run_phase(MODE_SEND_IDLE, 160, 1'b0);

    program_timing(16'd1, 16'd6, 16'd15, 1'b1);
    run_phase(MODE_RECV_STALL, 160, 1'b1);

    // zero window and hold time: conditions met at once
    program_timing(16'd0, 16'd0, 16'd0, 1'b0);
    run_phase(MODE_BOTH, 120, 1'b0);

    // unknown index must leave every register alone; the next writes follow on
    write_register(REG_UNUSED, REG_W'($urandom));
    program_timing(16'd3, 16'd30, 16'd40, 1'b1);
    run_phase(MODE_FLOW, 140, 1'b0);

    // all timing at the top of the range
    program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    run_phase(MODE_SEND_IDLE, 60, 1'b0);

    program_timing(16'd1, 16'hFFFF, 16'hFFFF, 1'b0);
    run_phase(MODE_RECV_STALL, 60, 1'b0);

    program_timing(16'd4, 16'd20, 16'd60, 1'b0);
    run_phase(MODE_BOTH, 120, 1'b0);

    program_timing(REG_W'($urandom_range(1, 3)), REG_W'($urandom_range(1, 40)),
                   REG_W'($urandom_range(1, 60)), 1'($urandom_range(1)));
    run_phase(MODE_FLOW, 120, 1'b0);

    $display("covered %0d ticks under %0d register settings, all idle and stall modes",
             ticks_taken, settings_run);
    $display("reported %0d clicks, %0d double clicks, %0d long presses",
             clicks_seen, doubles_seen, longs_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("timeout with %0d results outstanding", expected_reports.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
